[hw/rtl/tgrd_pkg.sv]
// shared types and constants for the tap gesture and rotation decoder
package tgrd_pkg;

    localparam int EXPRESSION_COUNT_DEF = 7;
    localparam int ACCEL_BITS_DEF       = 16;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int M_TDATA_W   = 16;
    localparam int SQ_SUM_W    = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_TAP_MAX_MS       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MULTI_TAP_GAP_MS = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IN_PLANE_MIN_SQ  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ROTATION   = 8'd3;

    localparam logic [15:0] TAP_MAX_MS_RST       = 16'd350;
    localparam logic [15:0] MULTI_TAP_GAP_MS_RST = 16'd600;
    localparam logic [30:0] IN_PLANE_MIN_SQ_RST  = 31'd2684355;
    localparam logic [1:0]  START_ROTATION_RST   = 2'd0;

    localparam logic [1:0] TAPS_FOR_ROTATION = 2'd3;

    localparam logic [1:0] ROT_UP    = 2'd0;
    localparam logic [1:0] ROT_RIGHT = 2'd1;
    localparam logic [1:0] ROT_DOWN  = 2'd2;
    localparam logic [1:0] ROT_LEFT  = 2'd3;

    typedef struct packed {
        logic       usable;
        logic [1:0] rot;
    } tgrd_snap_t;

    typedef struct packed {
        logic [1:0] taps_pending;
        logic       vad_toggle_request;
        logic       vad_off_request;
        logic       expression_advanced;
        logic [2:0] expression_index;
        logic       used_imu;
        logic       rotated;
        logic [1:0] rotation_quarter;
    } tgrd_result_t;

endpackage

[hw/rtl/tgrd_imu_snap.sv]
// accelerometer test and quarter-turn snap of the dominant in-plane axis
module tgrd_imu_snap
    import tgrd_pkg::*;
#(
    parameter int ACCEL_BITS = ACCEL_BITS_DEF
) (
    input  logic                  imu_ok,
    input  logic [ACCEL_BITS-1:0] mag_x,
    input  logic [ACCEL_BITS-1:0] mag_y,
    input  logic                  ax_neg,
    input  logic                  ay_neg,
    input  logic [SQ_SUM_W-1:0]   sq_sum,
    input  logic [30:0]           min_sq,
    output tgrd_snap_t            snap
);

    logic both_zero;
    logic x_wins;

    assign both_zero = (mag_x == '0) && (mag_y == '0);
    assign x_wins    = (mag_x > mag_y) || ((mag_x == mag_y) && ax_neg);

    always_comb begin
        snap.usable = imu_ok && !(sq_sum < {1'b0, min_sq});
        if (both_zero) begin
            snap.rot = ROT_RIGHT;
        end else if (x_wins) begin
            snap.rot = ax_neg ? ROT_LEFT : ROT_RIGHT;
        end else begin
            snap.rot = ay_neg ? ROT_DOWN : ROT_UP;
        end
    end

endmodule

[hw/rtl/tap_gesture_rotation_decoder.sv]
// top level: tap gesture decoder with accelerometer face rotation
//
// one button sample per s_ beat, one result per m_ beat, in the same order
// s_tdata carries now_ms, button flags and the two accelerometer readings
// m_tdata carries rotation, expression index, request pulses and tap count
// cfg_ writes set the tap limit, tap gap, imu threshold and start rotation;
// writing start_rotation also loads the current rotation
// an accepted beat is registered in the input stage, where the axis squares
// are registered too; the tap and rotation update then runs combinationally
// and the result lands in the output register, which drives m_tvalid
// throughput is one beat per cycle while the m_ side takes results, set by the state update
// a stalled m_ side holds its result; the input stage still takes one more
// beat and s_tready drops only when both stages are full
// reset clears all gesture state, restores register defaults and empties
// both stages
module tap_gesture_rotation_decoder
    import tgrd_pkg::*;
#(
    parameter int EXPRESSION_COUNT = EXPRESSION_COUNT_DEF,
    parameter int ACCEL_BITS       = ACCEL_BITS_DEF,
    localparam int S_TDATA_W = ((36 + 2 * ACCEL_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // now_ms[31:0], button_down, offline_mode, vad_enabled, imu_ok, accel_x, accel_y, zero pad
    input  logic [S_TDATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // rotation_quarter[1:0], rotated, used_imu, expression_index[2:0], expression_advanced,
    // vad_off_request, vad_toggle_request, taps_pending[1:0], zero pad
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SQ_W   = 2 * ACCEL_BITS;
    localparam int EXPR_W = $clog2(EXPRESSION_COUNT);
    localparam logic [EXPR_W-1:0] EXPR_LAST = EXPR_W'(EXPRESSION_COUNT - 1);

    // configuration registers
    logic [15:0] tap_max_reg;
    logic [15:0] gap_reg;
    logic [30:0] min_sq_reg;

    // gesture state
    logic              was_down_reg;
    logic [31:0]       press_start_reg;
    logic [31:0]       last_tap_reg;
    logic [1:0]        tap_cnt_reg;
    logic [EXPR_W-1:0] expr_reg;
    logic [1:0]        rot_reg;

    logic              was_down_next;
    logic [31:0]       press_start_next;
    logic [31:0]       last_tap_next;
    logic [1:0]        tap_cnt_next;
    logic [EXPR_W-1:0] expr_next;
    logic [1:0]        rot_next;

    // input stage
    logic                  in_valid_reg;
    logic [31:0]           now_reg;
    logic                  down_reg;
    logic                  offline_reg;
    logic                  vad_on_reg;
    logic                  imu_ok_reg;
    logic [ACCEL_BITS-1:0] mag_x_reg;
    logic [ACCEL_BITS-1:0] mag_y_reg;
    logic                  ax_neg_reg;
    logic                  ay_neg_reg;
    logic [SQ_W-1:0]       sq_x_reg;
    logic [SQ_W-1:0]       sq_y_reg;

    logic [ACCEL_BITS-1:0] ax_raw;
    logic [ACCEL_BITS-1:0] ay_raw;
    logic [ACCEL_BITS-1:0] mag_x_next;
    logic [ACCEL_BITS-1:0] mag_y_next;
    logic [SQ_W-1:0]       sq_x_next;
    logic [SQ_W-1:0]       sq_y_next;

    // output stage
    logic         out_valid_reg;
    tgrd_result_t out_reg;
    tgrd_result_t res_next;

    logic s_beat;
    logic adv;

    logic              rise;
    logic              fall;
    logic [31:0]       dur;
    logic [31:0]       since_tap;
    logic              is_tap;
    logic              gap_over;
    logic [1:0]        cnt_tap;
    logic [1:0]        cnt_mid;
    logic              third;
    logic              expire;
    logic [EXPR_W+2:0] expr_wide;
    logic [SQ_SUM_W-1:0] sq_sum;
    tgrd_snap_t        snap;

    assign cfg_ready = 1'b1;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_beat   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(tgrd_result_t)){1'b0}}, out_reg};

    // input capture: magnitudes and their squares
    assign ax_raw     = s_tdata[36 +: ACCEL_BITS];
    assign ay_raw     = s_tdata[36 + ACCEL_BITS +: ACCEL_BITS];
    assign mag_x_next = ax_raw[ACCEL_BITS-1] ? (~ax_raw + 1'b1) : ax_raw;
    assign mag_y_next = ay_raw[ACCEL_BITS-1] ? (~ay_raw + 1'b1) : ay_raw;
    assign sq_x_next  = {{ACCEL_BITS{1'b0}}, mag_x_next} * {{ACCEL_BITS{1'b0}}, mag_x_next};
    assign sq_y_next  = {{ACCEL_BITS{1'b0}}, mag_y_next} * {{ACCEL_BITS{1'b0}}, mag_y_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_beat) begin
            now_reg     <= s_tdata[31:0];
            down_reg    <= s_tdata[32];
            offline_reg <= s_tdata[33];
            vad_on_reg  <= s_tdata[34];
            imu_ok_reg  <= s_tdata[35];
            mag_x_reg   <= mag_x_next;
            mag_y_reg   <= mag_y_next;
            ax_neg_reg  <= ax_raw[ACCEL_BITS-1];
            ay_neg_reg  <= ay_raw[ACCEL_BITS-1];
            sq_x_reg    <= sq_x_next;
            sq_y_reg    <= sq_y_next;
        end
    end

    assign sq_sum = SQ_SUM_W'(sq_x_reg) + SQ_SUM_W'(sq_y_reg);

    tgrd_imu_snap #(
        .ACCEL_BITS (ACCEL_BITS)
    ) u_snap (
        .imu_ok (imu_ok_reg),
        .mag_x  (mag_x_reg),
        .mag_y  (mag_y_reg),
        .ax_neg (ax_neg_reg),
        .ay_neg (ay_neg_reg),
        .sq_sum (sq_sum),
        .min_sq (min_sq_reg),
        .snap   (snap)
    );

    // tap and rotation update
    assign rise      = down_reg && !was_down_reg;
    assign fall      = !down_reg && was_down_reg;
    assign dur       = now_reg - press_start_reg;
    assign since_tap = now_reg - last_tap_reg;
    assign is_tap    = fall && (dur < {16'd0, tap_max_reg});
    assign gap_over  = since_tap > {16'd0, gap_reg};
    assign cnt_tap   = gap_over ? 2'd1 : tap_cnt_reg + 2'd1;
    assign third     = is_tap && (cnt_tap == TAPS_FOR_ROTATION);

    always_comb begin
        if (third || (fall && !is_tap)) begin
            cnt_mid = 2'd0;
        end else if (is_tap) begin
            cnt_mid = cnt_tap;
        end else begin
            cnt_mid = tap_cnt_reg;
        end
    end

    // a tap just stamped now, so the gap cannot be over on that sample
    assign expire = (cnt_mid != 2'd0) && !is_tap && gap_over;

    always_comb begin
        was_down_next    = down_reg;
        press_start_next = rise ? now_reg : press_start_reg;
        last_tap_next    = is_tap ? now_reg : last_tap_reg;
        tap_cnt_next     = expire ? 2'd0 : cnt_mid;
        expr_next        = expr_reg;
        if (is_tap && offline_reg) begin
            expr_next = (expr_reg == EXPR_LAST) ? '0 : expr_reg + 1'b1;
        end
        rot_next = rot_reg;
        if (third) begin
            rot_next = snap.usable ? snap.rot : rot_reg + 2'd1;
        end
    end

    assign expr_wide = {3'b000, expr_next};

    always_comb begin
        res_next.rotation_quarter    = rot_next;
        res_next.rotated             = third;
        res_next.used_imu            = third && snap.usable;
        res_next.expression_index    = expr_wide[2:0];
        res_next.expression_advanced = is_tap && offline_reg;
        res_next.vad_off_request     = expire && !offline_reg && (cnt_mid == 2'd1) && vad_on_reg;
        res_next.vad_toggle_request  = expire && !offline_reg && (cnt_mid == 2'd2);
        res_next.taps_pending        = tap_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_down_reg    <= 1'b0;
            press_start_reg <= '0;
            last_tap_reg    <= '0;
            tap_cnt_reg     <= 2'd0;
            expr_reg        <= '0;
            rot_reg         <= START_ROTATION_RST;
            tap_max_reg     <= TAP_MAX_MS_RST;
            gap_reg         <= MULTI_TAP_GAP_MS_RST;
            min_sq_reg      <= IN_PLANE_MIN_SQ_RST;
        end else begin
            if (adv) begin
                was_down_reg    <= was_down_next;
                press_start_reg <= press_start_next;
                last_tap_reg    <= last_tap_next;
                tap_cnt_reg     <= tap_cnt_next;
                expr_reg        <= expr_next;
            end
            // start_rotation write loads the current rotation
            if (cfg_valid && (cfg_index == REG_START_ROTATION)) begin
                rot_reg <= cfg_data[1:0];
            end else if (adv) begin
                rot_reg <= rot_next;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_TAP_MAX_MS:       tap_max_reg <= cfg_data[15:0];
                    REG_MULTI_TAP_GAP_MS: gap_reg     <= cfg_data[15:0];
                    REG_IN_PLANE_MIN_SQ:  min_sq_reg  <= cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (adv) begin
            out_reg <= res_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_rotated_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.rotated |-> out_reg.taps_pending == 2'd0)
        else $error("rotation left taps pending");

    a_imu_needs_rotation: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.used_imu |-> out_reg.rotated)
        else $error("used_imu without rotation");

    a_vad_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.vad_off_request && out_reg.vad_toggle_request))
        else $error("both vad requests in one beat");

    a_expr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        expr_reg <= EXPR_LAST)
        else $error("expression index out of range");

    a_adv_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> out_valid_reg)
        else $error("result lost after update");

    a_count_below_three: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_cnt_reg != TAPS_FOR_ROTATION)
        else $error("tap count reached three in state");
`endif

endmodule

[test/tgrd_result_checker.sv]
// result checker for the tap gesture decoder: predicts each output beat and compares it
`timescale 1ns / 100ps
module tgrd_result_checker
    import tgrd_pkg::*;
#(
    parameter int S_W = 72
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_W-1:0]         s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     errors,
    output int                     pending
);
    localparam int AB = ACCEL_BITS_DEF;

    logic [15:0] tap_limit;
    logic [15:0] gap_limit;
    logic [30:0] imu_min_sq;
    logic        was_down;
    logic [31:0] press_t;
    logic [31:0] last_tap_t;
    logic [1:0]  taps;
    logic [2:0]  expr;
    logic [1:0]  rot;
    tgrd_result_t expected_q[$];

    initial begin
        errors = 0;
        pending = 0;
    end

    function automatic tgrd_snap_t snap_rotation(input logic ok,
                                                 input logic signed [AB-1:0] ax,
                                                 input logic signed [AB-1:0] ay);
        int x;
        int y;
        int mx;
        int my;
        longint sq;
        tgrd_snap_t s;
        x = int'(ax);
        y = int'(ay);
        mx = (x < 0) ? -x : x;
        my = (y < 0) ? -y : y;
        sq = longint'(mx) * longint'(mx) + longint'(my) * longint'(my);
        s.usable = ok && (sq >= longint'(imu_min_sq));
        if (!s.usable)
            s.rot = ROT_UP;
        else if (mx == 0 && my == 0)
            s.rot = ROT_RIGHT;
        // on the diagonals the y axis wins for ax > 0 and the x axis for ax < 0
        else if (mx > my || (mx == my && x < 0))
            s.rot = (x > 0) ? ROT_RIGHT : ROT_LEFT;
        else
            s.rot = (y > 0) ? ROT_UP : ROT_DOWN;
        return s;
    endfunction

    function automatic tgrd_result_t decode_sample(input logic [S_W-1:0] d);
        logic [31:0] now;
        logic [31:0] held_ms;
        logic [31:0] since_tap;
        logic down;
        logic off;
        logic vad_on;
        logic ok;
        logic signed [AB-1:0] ax;
        logic signed [AB-1:0] ay;
        tgrd_snap_t sn;
        tgrd_result_t r;
        now = d[31:0];
        down = d[32];
        off = d[33];
        vad_on = d[34];
        ok = d[35];
        ax = d[36 +: AB];
        ay = d[36 + AB +: AB];
        r = '0;
        if (down && !was_down) begin
            press_t = now;
        end else if (!down && was_down) begin
            held_ms = now - press_t;
            if (held_ms < {16'd0, tap_limit}) begin
                since_tap = now - last_tap_t;
                if (since_tap <= {16'd0, gap_limit})
                    taps = taps + 2'd1;
                else
                    taps = 2'd1;
                last_tap_t = now;
                if (off) begin
                    expr = 3'((expr + 1) % EXPRESSION_COUNT_DEF);
                    r.expression_advanced = 1'b1;
                end
                if (taps >= TAPS_FOR_ROTATION) begin
                    sn = snap_rotation(ok, ax, ay);
                    if (sn.usable) begin
                        rot = sn.rot;
                        r.used_imu = 1'b1;
                    end else begin
                        rot = rot + 2'd1;
                    end
                    r.rotated = 1'b1;
                    taps = 2'd0;
                end
            end else begin
                taps = 2'd0;
            end
        end
        since_tap = now - last_tap_t;
        if (taps != 2'd0 && since_tap > {16'd0, gap_limit}) begin
            if (!off) begin
                if (taps == 2'd1 && vad_on)
                    r.vad_off_request = 1'b1;
                else if (taps == 2'd2)
                    r.vad_toggle_request = 1'b1;
            end
            taps = 2'd0;
        end
        was_down = down;
        r.rotation_quarter = rot;
        r.expression_index = expr;
        r.taps_pending = taps;
        return r;
    endfunction

    always @(posedge aclk) begin
        tgrd_result_t want;
        tgrd_result_t got;
        if (!aresetn) begin
            tap_limit = TAP_MAX_MS_RST;
            gap_limit = MULTI_TAP_GAP_MS_RST;
            imu_min_sq = IN_PLANE_MIN_SQ_RST;
            rot = START_ROTATION_RST;
            was_down = 1'b0;
            press_t = '0;
            last_tap_t = '0;
            taps = '0;
            expr = '0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = tgrd_result_t'(m_tdata[$bits(tgrd_result_t)-1:0]);
                if (expected_q.size() == 0) begin
                    if (errors < 10)
                        $display("result beat with nothing expected at %0t: %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.rotation_quarter !== want.rotation_quarter ||
                        got.rotated !== want.rotated ||
                        got.used_imu !== want.used_imu ||
                        got.expression_index !== want.expression_index ||
                        got.expression_advanced !== want.expression_advanced ||
                        got.vad_off_request !== want.vad_off_request ||
                        got.vad_toggle_request !== want.vad_toggle_request ||
                        got.taps_pending !== want.taps_pending) begin
                        if (errors < 10) begin
                            $display("result mismatch at %0t", $time);
                            $display({"  expected rot %0d rotated %b imu %b expr %0d",
                                      " adv %b off %b tog %b taps %0d"},
                                     want.rotation_quarter, want.rotated, want.used_imu,
                                     want.expression_index, want.expression_advanced,
                                     want.vad_off_request, want.vad_toggle_request,
                                     want.taps_pending);
                            $display({"  actual   rot %0d rotated %b imu %b expr %0d",
                                      " adv %b off %b tog %b taps %0d"},
                                     got.rotation_quarter, got.rotated, got.used_imu,
                                     got.expression_index, got.expression_advanced,
                                     got.vad_off_request, got.vad_toggle_request,
                                     got.taps_pending);
                        end
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TAP_MAX_MS:       tap_limit = cfg_data[15:0];
                    REG_MULTI_TAP_GAP_MS: gap_limit = cfg_data[15:0];
                    REG_IN_PLANE_MIN_SQ:  imu_min_sq = cfg_data[30:0];
                    REG_START_ROTATION:   rot = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(decode_sample(s_tdata));
        end
        pending = expected_q.size();
    end

endmodule

[test/tb_tap_gesture_rotation_decoder.sv]
// testbench top for the tap gesture decoder: stimulus, flow control and verdict
`timescale 1ns / 100ps
module tb_tap_gesture_rotation_decoder;
    import tgrd_pkg::*;

    localparam int S_W             = ((36 + 2 * ACCEL_BITS_DEF + 7) / 8) * 8;
    localparam int AB              = ACCEL_BITS_DEF;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASES          = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = 8'hFF;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_W-1:0]         s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     errors;
    int                     pending;

    logic [31:0] t_now;
    int          tap_ms;
    int          gap_ms;
    int          steady_left;
    int          sent;
    int          stall_run;
    bit          hold_off_req;
    bit          hold_off_done;
    int          phase_items [PHASES] = '{250, 200, 150, 60, 200, 200, 190};

    tap_gesture_rotation_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tgrd_result_checker #(.S_W(S_W)) u_result_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    task automatic put(input logic [31:0] now, input logic down, input logic off,
                       input logic vad, input logic ok,
                       input logic [AB-1:0] ax, input logic [AB-1:0] ay);
        int gap;
        if (steady_left > 0) begin
            gap = 0;
            steady_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0)
                steady_left = $urandom_range(40, 150);
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_W - 36 - 2 * AB){1'b0}}, ay, ax, ok, vad, off, down, now};
        do @(posedge aclk); while (!s_tready);
        t_now = now;
        sent++;
    endtask

    task automatic press_release(input logic [31:0] press, input logic [31:0] rel,
                                 input logic off, input logic vad, input logic ok,
                                 input logic [AB-1:0] ax, input logic [AB-1:0] ay,
                                 input bit mid);
        put(press, 1'b1, off, vad, ok, ax, ay);
        if (mid)
            put(press + (rel - press) / 2, 1'b1, off, vad, ok, ax, ay);
        put(rel, 1'b0, off, vad, ok, ax, ay);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_TAP_MAX_MS)
            tap_ms = int'(data[15:0]);
        else if (idx == REG_MULTI_TAP_GAP_MS)
            gap_ms = int'(data[15:0]);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic pick_accel(output logic [AB-1:0] ax, output logic [AB-1:0] ay);
        int m;
        int n;
        m = $urandom_range(1, 32768);
        n = m * int'($urandom_range(0, 99)) / 100;
        case ($urandom_range(0, 7))
            0: begin
                // equal magnitudes on a diagonal
                ax = $urandom_range(0, 1) ? AB'(m) : AB'(-m);
                ay = $urandom_range(0, 1) ? AB'(m) : AB'(-m);
            end
            1: begin
                ax = '0;
                ay = '0;
            end
            2: begin
                ax = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                ay = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            end
            3: begin
                ax = $urandom_range(0, 1) ? AB'(m) : AB'(-m);
                ay = $urandom_range(0, 1) ? AB'(n) : AB'(-n);
            end
            4: begin
                ax = $urandom_range(0, 1) ? AB'(n) : AB'(-n);
                ay = $urandom_range(0, 1) ? AB'(m) : AB'(-m);
            end
            5: begin
                ax = AB'(int'($urandom_range(0, 3200)) - 1600);
                ay = AB'(int'($urandom_range(0, 3200)) - 1600);
            end
            default: begin
                ax = AB'($urandom);
                ay = AB'($urandom);
            end
        endcase
    endtask

    task automatic gesture();
        int r;
        int ntaps;
        logic [31:0] interval;
        logic [31:0] dur;
        logic [31:0] span;
        logic [31:0] rel;
        logic off;
        logic vad;
        logic ok;
        logic [AB-1:0] ax;
        logic [AB-1:0] ay;
        r = $urandom_range(0, 9);
        ntaps = (r < 3) ? 1 : (r < 6) ? 2 : (r < 9) ? 3 : 4;
        off = ($urandom_range(0, 2) == 0);
        vad = 1'($urandom_range(0, 1));
        for (int i = 0; i < ntaps; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                interval = $urandom_range(0, gap_ms);
            else if (r < 78)
                interval = gap_ms;
            else if (r < 86)
                interval = gap_ms + 1;
            else if (r < 94)
                interval = gap_ms + $urandom_range(2, 3000);
            else
                interval = $urandom;
            r = $urandom_range(0, 99);
            if (tap_ms == 0)
                dur = $urandom_range(0, 400);
            else if (r < 75)
                dur = $urandom_range(0, tap_ms - 1);
            else if (r < 83)
                dur = tap_ms - 1;
            else if (r < 91)
                dur = tap_ms;
            else
                dur = tap_ms + $urandom_range(1, 2000);
            span = (dur > interval) ? dur : interval;
            rel = t_now + span;
            if ($urandom_range(0, 9) == 0)
                off = ~off;
            if ($urandom_range(0, 9) == 0)
                vad = ~vad;
            ok = ($urandom_range(0, 4) != 0);
            pick_accel(ax, ay);
            press_release(rel - dur, rel, off, vad, ok, ax, ay, $urandom_range(0, 3) == 0);
        end
        // button-up samples, mostly past the gap so the gesture closes
        repeat ($urandom_range(0, 2)) begin
            pick_accel(ax, ay);
            if ($urandom_range(0, 3) == 0)
                put(t_now + $urandom_range(0, gap_ms), 1'b0, off, vad, 1'b1, ax, ay);
            else
                put(t_now + gap_ms + $urandom_range(1, 200), 1'b0, off, vad, 1'b1, ax, ay);
        end
    endtask

    task automatic noise_sample();
        logic [31:0] now;
        logic [AB-1:0] ax;
        logic [AB-1:0] ay;
        now = ($urandom_range(0, 3) == 0) ? $urandom : t_now + $urandom_range(0, 2000);
        pick_accel(ax, ay);
        put(now, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ax, ay);
    endtask

    task automatic set_phase(input int p);
        case (p)
            1: begin
                write_reg(REG_TAP_MAX_MS, 32'h0000_FFFF);
                write_reg(REG_MULTI_TAP_GAP_MS, 32'hFFFF_FFFF);
                write_reg(REG_IN_PLANE_MIN_SQ, 32'd0);
                write_reg(REG_START_ROTATION, 32'd3);
            end
            2: begin
                write_reg(REG_TAP_MAX_MS, 32'h1234_0001);
                write_reg(REG_MULTI_TAP_GAP_MS, 32'd1);
                write_reg(REG_IN_PLANE_MIN_SQ, 32'h7FFF_FFFF);
                write_reg(REG_START_ROTATION, 32'hFFFF_FFFE);
                write_reg(REG_UNUSED_LOW, $urandom);
                write_reg(REG_UNUSED_TOP, $urandom);
            end
            3: begin
                write_reg(REG_TAP_MAX_MS, 32'hFFFF_0000);
                write_reg(REG_MULTI_TAP_GAP_MS, 32'd0);
                write_reg(REG_IN_PLANE_MIN_SQ, 32'hFFFF_FFFF);
                write_reg(REG_START_ROTATION, 32'd5);
            end
            5: begin
                write_reg(REG_TAP_MAX_MS, {16'($urandom), TAP_MAX_MS_RST});
                write_reg(REG_MULTI_TAP_GAP_MS, {16'($urandom), MULTI_TAP_GAP_MS_RST});
                write_reg(REG_IN_PLANE_MIN_SQ, {1'b1, IN_PLANE_MIN_SQ_RST});
                write_reg(REG_START_ROTATION, {30'd0, START_ROTATION_RST});
            end
            4, 6: begin
                write_reg(REG_TAP_MAX_MS, {16'($urandom), 16'($urandom_range(1, 1500))});
                write_reg(REG_MULTI_TAP_GAP_MS, {16'($urandom), 16'($urandom_range(1, 3000))});
                if ($urandom_range(0, 1))
                    write_reg(REG_IN_PLANE_MIN_SQ, $urandom_range(0, 32'h7FFF_FFFF));
                else
                    write_reg(REG_IN_PLANE_MIN_SQ, $urandom_range(0, 8000000));
                write_reg(REG_START_ROTATION, $urandom);
            end
            default: ;
        endcase
    endtask

    // receiver: random stalls, plus one long hold-off once the random part starts
    initial begin
        int n;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
                repeat (n) begin
                    @(negedge aclk);
                    m_tready <= 1'b1;
                end
                n = pick_gap();
                repeat (n) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_run = 0;
        else
            stall_run++;
        if (stall_run >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        t_now = '0;
        tap_ms = int'(TAP_MAX_MS_RST);
        gap_ms = int'(MULTI_TAP_GAP_MS_RST);
        steady_left = 0;
        sent = 0;
        hold_off_req = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        put(32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
        // offline triple tap, last release reads a strong +x tilt
        press_release(32'd900, 32'd1000, 1'b1, 1'b0, 1'b1, 16'h7FFF, 16'h0000, 1'b0);
        press_release(32'd1200, 32'd1300, 1'b1, 1'b0, 1'b1, 16'h7FFF, 16'h0000, 1'b0);
        press_release(32'd1500, 32'd1600, 1'b1, 1'b0, 1'b1, 16'h7FFF, 16'h0000, 1'b0);
        // connected single tap with vad on, then expiry
        press_release(32'd2000, 32'd2100, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0);
        put(32'd2701, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000);
        // connected double tap at exactly the gap, then expiry
        press_release(32'd3000, 32'd3100, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0);
        press_release(32'd3500, 32'd3700, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0);
        put(32'd4301, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
        // tap just under the limit, then a press exactly at the limit clears it
        press_release(32'd5000, 32'd5349, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0);
        press_release(32'd5400, 32'd5750, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0);
        // triple tap across the timestamp wrap with no imu reading
        press_release(32'hFFFF_FF00, 32'hFFFF_FF10, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0);
        press_release(32'hFFFF_FF80, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0);
        press_release(32'h0000_0050, 32'h0000_0100, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h8000, 1'b0);

        hold_off_req = 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_phase(p);
            sent = 0;
            while (sent < phase_items[p]) begin
                if ($urandom_range(0, 11) == 0)
                    noise_sample();
                else
                    gesture();
            end
        end
        drain();
        repeat (8) @(negedge aclk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
